### hw/rtl/ws2812_pixel_serializer_macros.svh
// ============================================================================
// WS2812 pixel serializer assertion macros
// Shared concurrent assertion forms, reset-qualified on an active low reset.
// ============================================================================
`ifndef WS2812_PIXEL_SERIALIZER_MACROS_SVH
`define WS2812_PIXEL_SERIALIZER_MACROS_SVH

// same-cycle implication
`define WPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define WPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hw/rtl/wps_pkg.sv
// ============================================================================
// WS2812 pixel serializer package
// Transaction types, opcodes, register indexes, defaults and timer helpers.
// ============================================================================
package wps_pkg;

    localparam int TIMER_WIDTH = 16;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_LATCH = 2'd2;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ONE_HIGH  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ONE_LOW   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ZERO_HIGH = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ZERO_LOW  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LATCH_GAP = 3'd4;

    localparam logic [7:0]  ONE_HIGH_RESET  = 8'd15;
    localparam logic [7:0]  ONE_LOW_RESET   = 8'd11;
    localparam logic [7:0]  ZERO_HIGH_RESET = 8'd7;
    localparam logic [7:0]  ZERO_LOW_RESET  = 8'd20;
    localparam logic [15:0] LATCH_GAP_RESET = 16'd175;

    localparam logic [31:0] TIMER_MAX32 = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] scale;
    } in_item_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic rejected;
    } out_item_t;

    // item after colour scaling: GRB word ready to shift
    typedef struct packed {
        logic [1:0]  opcode;
        logic [23:0] pixel;
    } staged_item_t;

    typedef struct packed {
        logic [7:0]  one_high_ticks;
        logic [7:0]  one_low_ticks;
        logic [7:0]  zero_high_ticks;
        logic [7:0]  zero_low_ticks;
        logic [15:0] latch_gap_ticks;
    } cfg_t;

    // zero counts as one tick, counts beyond the timer saturate
    function automatic logic [TIMER_WIDTH-1:0] ticks_of(input logic [15:0] val);
        logic [31:0] t;
        t = 32'(val);
        if (t == 32'd0)
            t = 32'd1;
        if (t > TIMER_MAX32)
            t = TIMER_MAX32;
        return t[TIMER_WIDTH-1:0];
    endfunction

endpackage

### hw/rtl/ws2812_pixel_serializer.sv
// A transaction is registered in the input stage and its result in the result register.
// Throughput: one transaction per cycle while results are taken; a waiting result holds
// the line engine, and the input register takes one more transaction before in_ready drops.
// Reset (rst_n, asynchronous, active low): line idle and low, no result pending,
// timing registers back to their defaults.
// ============================================================================
// WS2812 pixel serializer
// Brightness scaling, GRB bit timing and latch gap on a one-wire LED line.
// ============================================================================
module ws2812_pixel_serializer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  wps_pkg::in_item_t                   in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output wps_pkg::out_item_t                  out_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [15:0]                         cfg_data
);

    wps_pkg::cfg_t         cfg;
    logic                  st_valid;
    logic                  st_ready;
    wps_pkg::staged_item_t st_item;

    wps_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wps_input_stage u_input_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .st_valid (st_valid),
        .st_ready (st_ready),
        .st_item  (st_item)
    );

    wps_line_engine u_line_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .st_valid  (st_valid),
        .st_ready  (st_ready),
        .st_item   (st_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

### hw/rtl/wps_cfg_regs.sv
// ============================================================================
// WS2812 configuration registers
// Bit timing and latch gap registers, written through the configuration port.
// ============================================================================
module wps_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [15:0]                         cfg_data,
    output wps_pkg::cfg_t                       cfg
);

    wps_pkg::cfg_t cfg_reg;
    wps_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                wps_pkg::CFG_ONE_HIGH:  cfg_next.one_high_ticks  = cfg_data[7:0];
                wps_pkg::CFG_ONE_LOW:   cfg_next.one_low_ticks   = cfg_data[7:0];
                wps_pkg::CFG_ZERO_HIGH: cfg_next.zero_high_ticks = cfg_data[7:0];
                wps_pkg::CFG_ZERO_LOW:  cfg_next.zero_low_ticks  = cfg_data[7:0];
                wps_pkg::CFG_LATCH_GAP: cfg_next.latch_gap_ticks = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.one_high_ticks  <= wps_pkg::ONE_HIGH_RESET;
            cfg_reg.one_low_ticks   <= wps_pkg::ONE_LOW_RESET;
            cfg_reg.zero_high_ticks <= wps_pkg::ZERO_HIGH_RESET;
            cfg_reg.zero_low_ticks  <= wps_pkg::ZERO_LOW_RESET;
            cfg_reg.latch_gap_ticks <= wps_pkg::LATCH_GAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hw/rtl/wps_input_stage.sv
// ============================================================================
// WS2812 input stage
// Scales pixel colours by brightness and registers the transaction.
// ============================================================================
module wps_input_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  wps_pkg::in_item_t     in_item,
    output logic                  st_valid,
    input  logic                  st_ready,
    output wps_pkg::staged_item_t st_item
);

    logic                  valid_reg;
    logic                  valid_next;
    wps_pkg::staged_item_t item_reg;
    logic [7:0]            green_s;
    logic [7:0]            red_s;
    logic [7:0]            blue_s;

    // (c*s)/255 via (x + (x>>8) + 1) >> 8, exact over the 8x8 product range
    function automatic logic [7:0] scale_colour(input logic [7:0] c, input logic [7:0] s);
        logic [15:0] prod;
        logic [16:0] sum;
        logic [7:0]  q;
        prod = 16'(c) * 16'(s);
        sum  = 17'(prod) + 17'(prod[15:8]) + 17'd1;
        q    = sum[15:8];
        if (s == 8'd0)
            q = 8'd0;
        else if (q == 8'd0 && c != 8'd0)
            q = 8'd1;
        return q;
    endfunction

    assign green_s  = scale_colour(in_item.green, in_item.scale);
    assign red_s    = scale_colour(in_item.red, in_item.scale);
    assign blue_s   = scale_colour(in_item.blue, in_item.scale);

    assign in_ready = !valid_reg || st_ready;
    assign st_valid = valid_reg;
    assign st_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (st_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.opcode <= in_item.opcode;
            item_reg.pixel  <= {green_s, red_s, blue_s};
        end
    end

endmodule

### hw/rtl/wps_line_engine.sv
// ============================================================================
// WS2812 line engine
// Bit and latch-gap timing, result register, one item per cycle unless stalled.
// ============================================================================
`include "ws2812_pixel_serializer_macros.svh"

module wps_line_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wps_pkg::cfg_t         cfg,
    input  logic                  st_valid,
    output logic                  st_ready,
    input  wps_pkg::staged_item_t st_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output wps_pkg::out_item_t    out_item
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2,
        PH_GAP  = 2'd3
    } phase_t;

    phase_t                             phase_reg, phase_next;
    logic [23:0]                        shifter_reg, shifter_next;
    logic [4:0]                         bits_reg, bits_next;
    logic [wps_pkg::TIMER_WIDTH-1:0]    timer_reg, timer_next;
    logic                               out_valid_reg, out_valid_next;
    wps_pkg::out_item_t                 out_item_reg, out_item_next;
    logic                               take;
    logic [23:0]                        shifted;

    assign st_ready  = !out_valid_reg || out_ready;
    assign take      = st_valid && st_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign shifted   = {shifter_reg[22:0], 1'b0};

    always_comb
    begin
        phase_next     = phase_reg;
        shifter_next   = shifter_reg;
        bits_next      = bits_reg;
        timer_next     = timer_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (take)
        begin
            out_item_next.rejected = 1'b0;
            case (st_item.opcode)
                wps_pkg::OP_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        if (timer_reg > wps_pkg::TIMER_WIDTH'(1))
                        begin
                            timer_next = timer_reg - wps_pkg::TIMER_WIDTH'(1);
                        end
                        else
                        begin
                            timer_next = '0;
                            case (phase_reg)
                                PH_HIGH:
                                begin
                                    phase_next = PH_LOW;
                                    timer_next = wps_pkg::ticks_of(shifter_reg[23]
                                        ? 16'(cfg.one_low_ticks)
                                        : 16'(cfg.zero_low_ticks));
                                end
                                PH_LOW:
                                begin
                                    shifter_next = shifted;
                                    if (bits_reg <= 5'd1)
                                    begin
                                        bits_next  = 5'd0;
                                        phase_next = PH_IDLE;
                                    end
                                    else
                                    begin
                                        // start the next bit from the new top bit
                                        bits_next  = bits_reg - 5'd1;
                                        phase_next = PH_HIGH;
                                        timer_next = wps_pkg::ticks_of(shifted[23]
                                            ? 16'(cfg.one_high_ticks)
                                            : 16'(cfg.zero_high_ticks));
                                    end
                                end
                                default:
                                begin
                                    phase_next = PH_IDLE;
                                end
                            endcase
                        end
                    end
                end
                wps_pkg::OP_PIXEL:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        out_item_next.rejected = 1'b1;
                    end
                    else
                    begin
                        shifter_next = st_item.pixel;
                        bits_next    = 5'd24;
                        phase_next   = PH_HIGH;
                        timer_next   = wps_pkg::ticks_of(st_item.pixel[23]
                            ? 16'(cfg.one_high_ticks)
                            : 16'(cfg.zero_high_ticks));
                    end
                end
                wps_pkg::OP_LATCH:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        out_item_next.rejected = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_GAP;
                        timer_next = wps_pkg::ticks_of(cfg.latch_gap_ticks);
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
            // a tick reports the level it drove; anything else the level it leaves
            if (st_item.opcode == wps_pkg::OP_TICK)
                out_item_next.line_level = (phase_reg == PH_HIGH);
            else
                out_item_next.line_level = (phase_next == PH_HIGH);
            out_item_next.busy_res = (phase_next != PH_IDLE);
            out_valid_next         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            shifter_reg   <= '0;
            bits_reg      <= '0;
            timer_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            shifter_reg   <= shifter_next;
            bits_reg      <= bits_next;
            timer_reg     <= timer_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    `WPS_ASSERT_NOW(a_no_bits_when_free, clk, rst_n, (phase_reg == PH_IDLE || phase_reg == PH_GAP), (bits_reg == 5'd0))
    `WPS_ASSERT_NOW(a_bit_phase_live, clk, rst_n, (phase_reg == PH_HIGH || phase_reg == PH_LOW), (bits_reg != 5'd0 && timer_reg != '0))
    `WPS_ASSERT_NOW(a_reject_only_busy, clk, rst_n, (out_valid_reg && out_item_reg.rejected), out_item_reg.busy_res)
    `WPS_ASSERT_NEXT(a_pixel_starts, clk, rst_n, (take && phase_reg == PH_IDLE && st_item.opcode == wps_pkg::OP_PIXEL), (phase_reg == PH_HIGH && bits_reg == 5'd24))

endmodule

### tb/ws2812_pixel_serializer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WS2812 pixel serializer checker
// Watches the input, result and register channels. Keeps its own model of the
// line engine and predicts every result. Compares each result field by field
// and hands the fault count, the outstanding result count and the predicted
// line state to the testbench top.
// ----------------------------------------------------------------------------
module ws2812_pixel_serializer_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  wps_pkg::in_item_t                   in_item,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  wps_pkg::out_item_t                  out_item,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [wps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [15:0]                         cfg_data,
    output int                                  fail_count,
    output int                                  pending,
    output logic                                line_busy
);

    localparam int TW = wps_pkg::TIMER_WIDTH;
    localparam logic [31:0] TIMER_TOP = 32'((64'd1 << TW) - 64'd1);

    typedef enum logic [1:0] {
        LINE_IDLE,
        LINE_HIGH,
        LINE_LOW,
        LINE_GAP
    } line_phase_e;

    logic [7:0]  one_high;
    logic [7:0]  one_low;
    logic [7:0]  zero_high;
    logic [7:0]  zero_low;
    logic [15:0] latch_gap;

    logic [23:0]  grb_shift;
    logic [4:0]   bits_left;
    line_phase_e  phase;
    logic [TW-1:0] phase_left;

    wps_pkg::out_item_t line_results_due[$];
    int faults;

    assign fail_count = faults;

    // a count of zero still lasts one tick; anything past the timer clips
    function automatic logic [TW-1:0] phase_ticks(input logic [15:0] count);
        logic [31:0] n;
        n = (count == 16'd0) ? 32'd1 : 32'(count);
        return (n > TIMER_TOP) ? TIMER_TOP[TW-1:0] : n[TW-1:0];
    endfunction

    function automatic logic [7:0] dim_colour(input logic [7:0] c, input logic [7:0] s);
        logic [15:0] prod;
        logic [15:0] q;
        if (s == 8'd0)
            return 8'd0;
        prod = 16'(c) * 16'(s);
        q = prod / 16'd255;
        // a lit colour never fades to black unless the scale is zero
        if (q == 16'd0 && c != 8'd0)
            q = 16'd1;
        return q[7:0];
    endfunction

    task automatic start_bit();
        phase = LINE_HIGH;
        phase_left = phase_ticks(grb_shift[23] ? 16'(one_high) : 16'(zero_high));
    endtask

    task automatic advance_line();
        if (phase == LINE_IDLE)
            return;
        if (phase_left > TW'(1))
        begin
            phase_left = phase_left - TW'(1);
            return;
        end
        phase_left = '0;
        case (phase)
            LINE_HIGH:
            begin
                phase = LINE_LOW;
                phase_left = phase_ticks(grb_shift[23] ? 16'(one_low) : 16'(zero_low));
            end
            LINE_LOW:
            begin
                grb_shift = grb_shift << 1;
                if (bits_left <= 5'd1)
                begin
                    bits_left = '0;
                    phase = LINE_IDLE;
                end
                else
                begin
                    bits_left = bits_left - 5'd1;
                    start_bit();
                end
            end
            default: phase = LINE_IDLE;
        endcase
    endtask

    task automatic step_line(input wps_pkg::in_item_t it, output wps_pkg::out_item_t res);
        res = '0;
        case (it.opcode)
            wps_pkg::OP_TICK:
            begin
                res.line_level = (phase == LINE_HIGH);
                advance_line();
            end
            wps_pkg::OP_PIXEL, wps_pkg::OP_LATCH:
            begin
                // drop requests while busy; the transfer carries on untouched
                if (phase != LINE_IDLE)
                    res.rejected = 1'b1;
                else if (it.opcode == wps_pkg::OP_PIXEL)
                begin
                    grb_shift = {dim_colour(it.green, it.scale), dim_colour(it.red, it.scale),
                                 dim_colour(it.blue, it.scale)};
                    bits_left = 5'd24;
                    start_bit();
                end
                else
                begin
                    phase = LINE_GAP;
                    phase_left = phase_ticks(latch_gap);
                end
                res.line_level = (phase == LINE_HIGH);
            end
            default: res.line_level = (phase == LINE_HIGH);
        endcase
        res.busy_res = (phase != LINE_IDLE);
    endtask

    task automatic report_fault(input string what, input int want, input int got);
        $display("%0t ns: bad %s, expected %0d, got %0d", $time, what, want, got);
        faults++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        wps_pkg::out_item_t due;
        if (!rst_n)
        begin
            one_high   = wps_pkg::ONE_HIGH_RESET;
            one_low    = wps_pkg::ONE_LOW_RESET;
            zero_high  = wps_pkg::ZERO_HIGH_RESET;
            zero_low   = wps_pkg::ZERO_LOW_RESET;
            latch_gap  = wps_pkg::LATCH_GAP_RESET;
            grb_shift  = '0;
            bits_left  = '0;
            phase      = LINE_IDLE;
            phase_left = '0;
            line_results_due.delete();
            faults     = 0;
            pending   <= 0;
            line_busy <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (line_results_due.size() == 0)
                    report_fault("result with nothing outstanding", 0, 1);
                else
                begin
                    due = line_results_due.pop_front();
                    if (out_item.line_level !== due.line_level)
                        report_fault("line_level", int'(due.line_level),
                                     int'(out_item.line_level));
                    if (out_item.busy_res !== due.busy_res)
                        report_fault("busy_res", int'(due.busy_res), int'(out_item.busy_res));
                    if (out_item.rejected !== due.rejected)
                        report_fault("rejected", int'(due.rejected), int'(out_item.rejected));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    wps_pkg::CFG_ONE_HIGH:  one_high  = cfg_data[7:0];
                    wps_pkg::CFG_ONE_LOW:   one_low   = cfg_data[7:0];
                    wps_pkg::CFG_ZERO_HIGH: zero_high = cfg_data[7:0];
                    wps_pkg::CFG_ZERO_LOW:  zero_low  = cfg_data[7:0];
                    wps_pkg::CFG_LATCH_GAP: latch_gap = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                step_line(in_item, due);
                line_results_due.push_back(due);
            end
            pending   <= line_results_due.size();
            line_busy <= (phase != LINE_IDLE);
        end
    end

endmodule

### tb/ws2812_pixel_serializer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WS2812 pixel serializer testbench
// Drives ticks, pixels and latch requests with random gaps and result stalls
// over several timing settings, from the smallest counts up to a latch gap
// wider than a byte. A checker beside the block predicts and compares every
// result; this module makes the traffic and gives the verdict.
// ----------------------------------------------------------------------------
module ws2812_pixel_serializer_tb;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic [wps_pkg::CFG_INDEX_WIDTH-1:0] CFG_SPARE = '1;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int RANDOM_ITEMS = 300;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    wps_pkg::in_item_t in_item;
    logic out_valid;
    logic out_ready;
    wps_pkg::out_item_t out_item;
    logic cfg_valid;
    logic cfg_ready;
    logic [wps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [15:0] cfg_data;

    int   fail_count;
    int   pending;
    logic line_busy;

    bit rush;
    bit in_calm;
    bit out_calm;
    int sent_count;
    int taken_count;
    int random_sent;
    int cycle_count;
    int owed;

    // timing as last written, only to size the tick runs
    logic [7:0]  one_high;
    logic [7:0]  one_low;
    logic [7:0]  zero_high;
    logic [7:0]  zero_low;
    logic [15:0] latch_gap;

    ws2812_pixel_serializer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ws2812_pixel_serializer_checker line_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .line_busy  (line_busy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int eff(input logic [15:0] v);
        return (v == 16'd0) ? 1 : int'(v);
    endfunction

    // upper bound on the ticks one pixel keeps the line busy
    function automatic int pixel_len();
        int hi;
        int lo;
        hi = (eff(16'(one_high)) > eff(16'(zero_high))) ? eff(16'(one_high))
                                                          : eff(16'(zero_high));
        lo = (eff(16'(one_low)) > eff(16'(zero_low))) ? eff(16'(one_low))
                                                        : eff(16'(zero_low));
        return 24 * (hi + lo);
    endfunction

    function automatic wps_pkg::in_item_t make_item(input logic [1:0] op, input logic [7:0] r,
                                                     input logic [7:0] g, input logic [7:0] b,
                                                     input logic [7:0] s);
        wps_pkg::in_item_t it;
        it.opcode = op;
        it.red    = r;
        it.green  = g;
        it.blue   = b;
        it.scale  = s;
        return it;
    endfunction

    function automatic wps_pkg::in_item_t noise_item(input logic [1:0] op);
        logic [63:0] noise;
        wps_pkg::in_item_t it;
        noise = {$urandom, $urandom};
        it = noise[$bits(wps_pkg::in_item_t)-1:0];
        it.opcode = op;
        return it;
    endfunction

    function automatic logic [7:0] pick_colour();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 8'h00;
        if (r < 4)
            return 8'hFF;
        if (r == 4)
            return 8'h01;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_scale();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        if (r == 2)
            return 8'($urandom_range(1, 3));
        return 8'($urandom);
    endfunction

    // mostly ticks while the line is busy, mostly requests once it should be free
    function automatic wps_pkg::in_item_t random_item();
        int r;
        logic [1:0] op;
        r = $urandom_range(0, 99);
        if (owed > 0)
            op = (r < 90) ? wps_pkg::OP_TICK : (r < 94) ? wps_pkg::OP_PIXEL :
                 (r < 97) ? wps_pkg::OP_LATCH : OP_SPARE;
        else
            op = (r < 45) ? wps_pkg::OP_PIXEL : (r < 70) ? wps_pkg::OP_LATCH :
                 (r < 92) ? wps_pkg::OP_TICK : OP_SPARE;
        if (op == wps_pkg::OP_PIXEL)
            return make_item(op, pick_colour(), pick_colour(), pick_colour(), pick_scale());
        return noise_item(op);
    endfunction

    function automatic logic [15:0] rand_count();
        logic [15:0] v;
        v = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(7, 24)) : 16'($urandom_range(0, 6));
        // junk in the upper byte must be ignored
        if ($urandom_range(0, 3) == 0)
            v = v | (16'($urandom) & 16'hFF00);
        return v;
    endfunction

    function automatic logic [15:0] rand_gap();
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom_range(0, 2));
        return 16'($urandom_range(3, 250));
    endfunction

    task automatic push_item(input wps_pkg::in_item_t it);
        int gap;
        gap = (rush || in_calm) ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!(in_valid && in_ready));
        sent_count++;
        if (sent_count % 32 == 0)
            in_calm = ($urandom_range(0, 3) == 0);
    endtask

    task automatic tick_run(input int n);
        repeat (n) push_item(noise_item(wps_pkg::OP_TICK));
    endtask

    // tick until the line is free, then let every result come home
    task automatic drain_line();
        in_valid <= 1'b0;
        @(posedge clk);
        while (line_busy)
        begin
            push_item(noise_item(wps_pkg::OP_TICK));
            in_valid <= 1'b0;
            @(posedge clk);
        end
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        owed = 0;
    endtask

    task automatic write_timing(input logic [15:0] oh, input logic [15:0] ol,
                                input logic [15:0] zh, input logic [15:0] zl,
                                input logic [15:0] gap);
        logic [15:0] vals [6];
        logic [wps_pkg::CFG_INDEX_WIDTH-1:0] regs [6];
        drain_line();
        vals = '{oh, ol, zh, zl, gap, 16'($urandom)};
        regs = '{wps_pkg::CFG_ONE_HIGH, wps_pkg::CFG_ONE_LOW, wps_pkg::CFG_ZERO_HIGH,
                 wps_pkg::CFG_ZERO_LOW, wps_pkg::CFG_LATCH_GAP, CFG_SPARE};
        // the last write goes to an unmapped index and must change nothing
        regs[5] = wps_pkg::CFG_INDEX_WIDTH'($urandom_range(int'(wps_pkg::CFG_LATCH_GAP) + 1,
                                                           int'(CFG_SPARE)));
        for (int i = 0; i < 6; i++)
        begin
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!(cfg_valid && cfg_ready));
        end
        cfg_valid <= 1'b0;
        one_high  = oh[7:0];
        one_low   = ol[7:0];
        zero_high = zh[7:0];
        zero_low  = zl[7:0];
        latch_gap = gap;
    endtask

    task automatic random_traffic(input int count);
        wps_pkg::in_item_t it;
        repeat (count)
        begin
            // now and then hold off until every result is back
            if ($urandom_range(0, 59) == 0)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            it = random_item();
            push_item(it);
            if (it.opcode == wps_pkg::OP_TICK)
            begin
                if (owed > 0)
                    owed--;
            end
            else if (owed == 0 && it.opcode == wps_pkg::OP_PIXEL)
                owed = pixel_len();
            else if (owed == 0 && it.opcode == wps_pkg::OP_LATCH)
                owed = eff(latch_gap);
            random_sent++;
        end
    endtask

    initial
    begin : sink
        int stall;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = (rush || out_calm) ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            taken_count++;
            if (taken_count % 40 == 0)
                out_calm = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin : stim
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        one_high  = wps_pkg::ONE_HIGH_RESET;
        one_low   = wps_pkg::ONE_LOW_RESET;
        zero_high = wps_pkg::ZERO_HIGH_RESET;
        zero_low  = wps_pkg::ZERO_LOW_RESET;
        latch_gap = wps_pkg::LATCH_GAP_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timing: an idle tick, the unused opcode, a latch and requests during it
        push_item(noise_item(wps_pkg::OP_TICK));
        push_item(make_item(OP_SPARE, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        push_item(noise_item(wps_pkg::OP_LATCH));
        push_item(make_item(wps_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        push_item(noise_item(wps_pkg::OP_LATCH));
        push_item(noise_item(OP_SPARE));
        tick_run(eff(latch_gap));

        // shortest timing, colour and scale extremes
        write_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        push_item(make_item(wps_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        tick_run(pixel_len());
        push_item(make_item(wps_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h00));
        tick_run(pixel_len());
        push_item(make_item(wps_pkg::OP_PIXEL, 8'h01, 8'h00, 8'h02, 8'h01));
        push_item(noise_item(wps_pkg::OP_LATCH));
        tick_run(pixel_len());
        push_item(make_item(wps_pkg::OP_PIXEL, 8'h80, 8'h01, 8'hFE, 8'h80));
        tick_run(pixel_len());
        push_item(noise_item(wps_pkg::OP_LATCH));
        tick_run(2);
        push_item(make_item(wps_pkg::OP_PIXEL, 8'h00, 8'hFF, 8'h00, 8'h7F));
        tick_run(pixel_len());

        // zero counts behave as one tick
        write_timing(16'hFF00, 16'd0, 16'hAB00, 16'd0, 16'd0);
        push_item(make_item(wps_pkg::OP_PIXEL, 8'hA5, 8'h5A, 8'hC3, 8'hFF));
        tick_run(pixel_len());
        push_item(noise_item(wps_pkg::OP_LATCH));
        tick_run(2);
        random_traffic(150);

        // one long bit and a latch gap past one byte, run flat out
        rush = 1'b1;
        write_timing(16'd24, 16'd1, 16'd1, 16'd1, 16'h0100);
        push_item(make_item(wps_pkg::OP_PIXEL, 8'h00, 8'h80, 8'h00, 8'hFF));
        tick_run(24 + 1 + 23 * 2);
        push_item(noise_item(wps_pkg::OP_LATCH));
        tick_run(eff(latch_gap));
        drain_line();
        rush = 1'b0;

        while (random_sent < RANDOM_ITEMS)
        begin
            write_timing(rand_count(), rand_count(), rand_count(), rand_count(), rand_gap());
            random_traffic(150);
        end

        drain_line();
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
